### rtl/point_marker_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// Point marker vertex generator: assertion macros
// Shared concurrent-check wrappers, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_MARKER_VERTEX_GENERATOR_DEFINES_SVH
`define POINT_MARKER_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define PMVG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmvg: same-cycle check failed");

// next-cycle implication
`define PMVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmvg: next-cycle check failed");

`endif

### rtl/pmvg_pkg.sv
// ----------------------------------------------------------------------------
// pmvg_pkg
// Types, codes and constant tables for the point marker vertex generator.
// ----------------------------------------------------------------------------
package pmvg_pkg;

    // marker style codes
    localparam logic [2:0] STYLE_NONE     = 3'd0;
    localparam logic [2:0] STYLE_CROSS    = 3'd1;
    localparam logic [2:0] STYLE_DISC     = 3'd2;
    localparam logic [2:0] STYLE_RHOMBUS  = 3'd3;
    localparam logic [2:0] STYLE_SQUARE   = 3'd4;
    localparam logic [2:0] STYLE_TRIANGLE = 3'd5;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_STYLE = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam int DISC_STEPS = 16;
    localparam int VTX_W      = $clog2(DISC_STEPS + 1);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // 1.5 * 256 * round(sqrt(3)/2 * 65536)
    localparam logic [32:0] TRI_K = 33'd21794304;

    typedef logic signed [27:0] coord_t;   // scaled point, full width
    typedef logic signed [17:0] offs_t;    // marker offset, Q9.8

    typedef struct packed {
        coord_t     px;
        coord_t     py;
        logic [2:0] style;
        logic [6:0] half_w;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef logic signed [15:0] disc_tab_t [0:DISC_STEPS];

    localparam int QUARTER_SINE [0:32] = '{
        0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
        8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
        14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207,
        16305, 16364, 16384
    };

    // quarter wave with linear interpolation, r in 1/32768 turn, 0..8192
    function automatic int quarter_lookup(int r);
        int idx;
        int f;
        idx = r >> 8;
        f   = r & 255;
        if (idx >= 32)
            return QUARTER_SINE[32];
        return QUARTER_SINE[idx]
             + (((QUARTER_SINE[idx + 1] - QUARTER_SINE[idx]) * f + 128) >> 8);
    endfunction

    // Q2.14 sine of a phase in 1/32768 turn
    function automatic int sine_q14(int phase);
        int ph;
        int q;
        int r;
        int mag;
        ph  = phase & 32767;
        q   = ph >> 13;
        r   = ph & 8191;
        mag = ((q & 1) != 0) ? quarter_lookup(8192 - r) : quarter_lookup(r);
        return ((q & 2) != 0) ? -mag : mag;
    endfunction

    function automatic disc_tab_t disc_table(bit use_cos);
        disc_tab_t t;
        int ph;
        for (int i = 0; i <= DISC_STEPS; i++) begin
            ph   = (i * 32768) / DISC_STEPS;
            t[i] = 16'(sine_q14(use_cos ? ph + 8192 : ph));
        end
        return t;
    endfunction

    localparam disc_tab_t DISC_COS = disc_table(1'b1);
    localparam disc_tab_t DISC_SIN = disc_table(1'b0);

endpackage

### rtl/point_marker_vertex_generator.sv
// ----------------------------------------------------------------------------
// point_marker_vertex_generator
// Turns plotted points into marker outline vertices for a chosen style.
// ----------------------------------------------------------------------------
// Each accepted point beat is scaled by scale_factor (Q4.12) and, unless it is
// flagged invalid or the style is none (codes 0, 6, 7), yields the vertices of
// its marker, one vertex beat per clock unless out_stall holds the output:
// cross 4, rhombus 5, square 5, triangle 4, disc DISC_STEPS+1 (17). Skipped
// points produce nothing. The front takes the next point while the back is
// still walking the previous one: a four-entry queue sits between them, and
// the output register lets the back run again in the cycle a stalled vertex
// is taken. From an input beat to its first vertex, a point passes the scale
// multiply register, the queue, the offset stage and the output register.
// Coordinates are Q15.8; every vertex coordinate saturates to the 24-bit
// signed range. Registers sit on an APB port at byte addresses 0
// (marker_style), 4 (point_width), 8 (scale_factor) and are only to be
// written while no point is in flight.
// ----------------------------------------------------------------------------
module point_marker_vertex_generator (
    input  logic                clk,
    input  logic                rst_n,

    // point channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  point_x,
    input  logic signed [23:0]  point_y,
    input  logic                point_invalid,

    // vertex channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  vertex_x,
    output logic signed [23:0]  vertex_y,
    output logic                end_of_polygon,
    output logic                last_of_point,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pmvg_pkg::*;

    // configuration registers
    logic [2:0]   style_reg;
    logic [7:0]   width_reg;
    logic [15:0]  scale_reg;
    logic         cfg_wr;
    logic [1:0]   reg_idx;

    // front/back coupling
    entry_t       push_entry, head;
    q_status_t    q_status;
    logic         push, pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= STYLE_NONE;
            width_reg <= 8'd2;
            scale_reg <= 16'd4096;     // 1.0
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_STYLE: style_reg <= pwdata[2:0];
                REG_WIDTH: width_reg <= pwdata[7:0];
                REG_SCALE: scale_reg <= pwdata[15:0];
                default:   ;           // unmapped, write ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STYLE: prdata = {29'd0, style_reg};
            REG_WIDTH: prdata = {24'd0, width_reg};
            REG_SCALE: prdata = {16'd0, scale_reg};
            default:   prdata = '0;
        endcase
    end

    // front: accept, drop skipped points, scale
    pmvg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_invalid (point_invalid),
        .marker_style  (style_reg),
        .point_width   (width_reg),
        .scale_factor  (scale_reg),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    // decoupling queue
    pmvg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: vertex sequencer, offset and saturation stages
    pmvg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .end_of_polygon (end_of_polygon),
        .last_of_point  (last_of_point)
    );

endmodule

### rtl/pmvg_queue.sv
// ----------------------------------------------------------------------------
// pmvg_queue
// Small flop FIFO of classified points between front and back.
// ----------------------------------------------------------------------------
`include "point_marker_vertex_generator_defines.svh"

module pmvg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pmvg_pkg::entry_t   push_entry,
    input  logic               pop,
    output pmvg_pkg::entry_t   head,
    output pmvg_pkg::q_status_t status
);
    import pmvg_pkg::*;

    entry_t               store [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_entry;
    end

    assign head         = store[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

    `PMVG_ASSERT_IMPL(a_no_push_full, push, !status.full)
    `PMVG_ASSERT_IMPL(a_no_pop_empty, pop, !status.empty)
    `PMVG_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

### rtl/pmvg_front.sv
// ----------------------------------------------------------------------------
// pmvg_front
// Accepts points, drops skipped ones, scales the rest and queues them.
// ----------------------------------------------------------------------------
module pmvg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  point_x,
    input  logic signed [23:0]  point_y,
    input  logic                point_invalid,
    input  logic [2:0]          marker_style,
    input  logic [7:0]          point_width,
    input  logic [15:0]         scale_factor,
    input  pmvg_pkg::q_status_t q_status,
    output logic                push,
    output pmvg_pkg::entry_t    push_entry
);
    import pmvg_pkg::*;

    logic                stage_valid_reg, stage_valid_next;
    logic signed [39:0]  prod_x_reg, prod_y_reg;
    logic [2:0]          style_reg;
    logic [6:0]          half_w_reg;
    logic                take, keep;
    logic signed [39:0]  rnd_x, rnd_y;

    assign in_stall = stage_valid_reg && q_status.full;
    assign take     = in_valid && !in_stall;
    assign keep     = take && !point_invalid
                      && (marker_style inside {[STYLE_CROSS:STYLE_TRIANGLE]});
    assign push     = stage_valid_reg && !q_status.full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (keep)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // Q15.8 * Q4.12, rounded back to Q.8 at push time
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            prod_x_reg <= 40'(point_x * $signed({1'b0, scale_factor}));
            prod_y_reg <= 40'(point_y * $signed({1'b0, scale_factor}));
            style_reg  <= marker_style;
            half_w_reg <= point_width[7:1];
        end
    end

    // round half up: floor((p + 2048) / 4096)
    assign rnd_x = prod_x_reg + 40'sd2048;
    assign rnd_y = prod_y_reg + 40'sd2048;

    assign push_entry.px     = rnd_x[39:12];
    assign push_entry.py     = rnd_y[39:12];
    assign push_entry.style  = style_reg;
    assign push_entry.half_w = half_w_reg;

endmodule

### rtl/pmvg_back.sv
// ----------------------------------------------------------------------------
// pmvg_back
// Walks the marker outline of the queue head, one vertex a beat.
// ----------------------------------------------------------------------------
`include "point_marker_vertex_generator_defines.svh"

module pmvg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pmvg_pkg::entry_t    head,
    input  pmvg_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  vertex_x,
    output logic signed [23:0]  vertex_y,
    output logic                end_of_polygon,
    output logic                last_of_point
);
    import pmvg_pkg::*;

    function automatic logic signed [23:0] sat24(logic signed [28:0] v);
        if (v > 29'sd8388607)
            return 24'sh7FFFFF;
        if (v < -29'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    logic [VTX_W-1:0]    vtx_reg, vtx_next, last_idx;
    logic                advance, issue, is_final;
    logic [6:0]          w;
    offs_t               h512, h384, h256, h192, tri_d, disc_x, disc_y;
    offs_t               dx, dy;
    logic                eop, fin;
    logic signed [23:0]  cprod, sprod, cround, sround;
    logic [32:0]         tprod;

    // offset stage
    logic                a_valid_reg;
    coord_t              a_px_reg, a_py_reg;
    offs_t               a_dx_reg, a_dy_reg;
    logic                a_eop_reg, a_fin_reg;

    // output stage
    logic                out_valid_reg;
    logic signed [23:0]  vx_reg, vy_reg;
    logic                eop_reg, fin_reg;
    logic signed [28:0]  sum_x, sum_y;

    assign advance  = !out_valid_reg || !out_stall;
    assign issue    = advance && !q_status.empty;
    assign is_final = (vtx_reg == last_idx);
    assign pop      = issue && is_final;
    assign vtx_next = issue ? (is_final ? '0 : vtx_reg + 1'b1) : vtx_reg;

    always_comb
    begin
        case (head.style)
            STYLE_CROSS:    last_idx = VTX_W'(3);
            STYLE_DISC:     last_idx = VTX_W'(DISC_STEPS);
            STYLE_RHOMBUS:  last_idx = VTX_W'(4);
            STYLE_SQUARE:   last_idx = VTX_W'(4);
            STYLE_TRIANGLE: last_idx = VTX_W'(3);
            default:        last_idx = '0;
        endcase
    end

    assign w    = head.half_w;
    assign h512 = 18'({w, 9'b0});
    assign h384 = 18'({w, 8'b0}) + 18'({w, 7'b0});
    assign h256 = 18'({w, 8'b0});
    assign h192 = 18'({w, 7'b0}) + 18'({w, 6'b0});

    // disc: round(w*256*s / 16384) == floor((w*s + 32) / 64)
    assign cprod  = 24'($signed({1'b0, w}) * DISC_COS[vtx_reg]);
    assign sprod  = 24'($signed({1'b0, w}) * DISC_SIN[vtx_reg]);
    assign cround = cprod + 24'sd32;
    assign sround = sprod + 24'sd32;
    assign disc_x = 18'(cround >>> 6);
    assign disc_y = 18'(sround >>> 6);

    // triangle half base, rounded
    assign tprod = 33'(w) * TRI_K + 33'd32768;
    assign tri_d = 18'(tprod[32:16]);

    always_comb
    begin
        dx  = '0;
        dy  = '0;
        eop = 1'b0;
        fin = is_final;
        case (head.style)
            STYLE_CROSS:
            begin
                case (vtx_reg[1:0])
                    2'd0:    dx = -h512;
                    2'd1:    dx = h512;
                    2'd2:    dy = -h512;
                    default: dy = h512;
                endcase
                eop = vtx_reg[0];
            end
            STYLE_DISC:
            begin
                dx  = disc_x;
                dy  = disc_y;
                eop = is_final;
            end
            STYLE_RHOMBUS:
            begin
                case (vtx_reg[1:0])
                    2'd1:    dy = h384;
                    2'd2:    dx = h384;
                    2'd3:    dy = -h384;
                    default: dx = -h384;
                endcase
                eop = is_final;
            end
            STYLE_SQUARE:
            begin
                case (vtx_reg[1:0])
                    2'd1:
                    begin
                        dx = h256;
                        dy = -h256;
                    end
                    2'd2:
                    begin
                        dx = h256;
                        dy = h256;
                    end
                    2'd3:
                    begin
                        dx = -h256;
                        dy = h256;
                    end
                    default:
                    begin
                        dx = -h256;
                        dy = -h256;
                    end
                endcase
                eop = is_final;
            end
            STYLE_TRIANGLE:
            begin
                case (vtx_reg[1:0])
                    2'd1:
                    begin
                        dx = tri_d;
                        dy = h192;
                    end
                    2'd2:
                    begin
                        dx = -tri_d;
                        dy = h192;
                    end
                    default: dy = -h384;
                endcase
                eop = is_final;
            end
            default:
            begin
                eop = 1'b1;
            end
        endcase
    end

    assign sum_x = 29'(a_px_reg) + 29'(a_dx_reg);
    assign sum_y = 29'(a_py_reg) + 29'(a_dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vtx_reg <= vtx_next;
            if (advance)
            begin
                a_valid_reg   <= issue;
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_px_reg  <= head.px;
            a_py_reg  <= head.py;
            a_dx_reg  <= dx;
            a_dy_reg  <= dy;
            a_eop_reg <= eop;
            a_fin_reg <= fin;
        end
        if (advance && a_valid_reg)
        begin
            vx_reg  <= sat24(sum_x);
            vy_reg  <= sat24(sum_y);
            eop_reg <= a_eop_reg;
            fin_reg <= a_fin_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign vertex_x       = vx_reg;
    assign vertex_y       = vy_reg;
    assign end_of_polygon = eop_reg;
    assign last_of_point  = fin_reg;

    `PMVG_ASSERT_IMPL(a_last_closes, out_valid_reg && fin_reg, eop_reg)
    `PMVG_ASSERT_IMPL(a_vtx_bound, issue, vtx_reg <= last_idx)
    `PMVG_ASSERT_NEXT(a_pop_rewinds, pop, vtx_reg == '0)

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Point marker vertex generator testbench
// Streams plotted points through the block under every marker style and a
// range of widths and scales. A local model turns each accepted point into the
// vertex beats it should produce. A checker compares every vertex beat with
// the oldest one outstanding. Both channels idle and stall at random, phase by
// phase.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pmvg_pkg::*;

    // style codes the block treats as none
    localparam logic [2:0] STYLE_UNUSED_A = 3'd6;
    localparam logic [2:0] STYLE_UNUSED_B = 3'd7;

    localparam int      DISC_SEGMENTS = 16;      // disc outline steps, one turn
    localparam int      STALL_LIMIT   = 4000;    // cycles with no beat at all
    localparam int      SETTLE_CYCLES = 12;      // queue depth + pipeline, padded
    localparam longint  COORD_MIN     = -64'sd8388608;
    localparam longint  COORD_MAX     = 64'sd8388607;

    // quarter wave of the sine in Q2.14, 1/128 turn per entry
    localparam int QUARTER_WAVE [0:32] = '{
        0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
        8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
        14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207,
        16305, 16364, 16384
    };

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               eop;
        logic               lop;
    } vertex_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [23:0] point_x = '0;
    logic signed [23:0] point_y = '0;
    logic               point_invalid = 1'b0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic               end_of_polygon;
    logic               last_of_point;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // register copies, at their reset values
    logic [2:0]         style_m = STYLE_NONE;
    logic [7:0]         width_m = 8'd2;
    logic [15:0]        scale_m = 16'd4096;

    vertex_t            pending_vertices [$];

    int                 idle_pct = 0;        // sender idle chance per cycle
    int                 stall_pct = 0;       // receiver stall chance per cycle
    int                 errors = 0;
    int                 points_sent = 0;
    int                 points_skipped = 0;
    int                 vertices_expected = 0;
    int                 vertices_checked = 0;
    int                 style_points [0:7] = '{default: 0};
    int                 quiet_cycles = 0;

    always #6 clk = ~clk;

    point_marker_vertex_generator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_invalid  (point_invalid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .end_of_polygon (end_of_polygon),
        .last_of_point  (last_of_point),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Vertex model
    // ------------------------------------------------------------------

    // interpolated quarter wave, r in 1/32768 turn, 0..8192
    function automatic longint sine_ramp(int r);
        int idx;
        int f;
        idx = r >> 8;
        f   = r & 255;
        if (idx >= 32)
            return QUARTER_WAVE[32];
        return QUARTER_WAVE[idx]
             + (((QUARTER_WAVE[idx + 1] - QUARTER_WAVE[idx]) * f + 128) >> 8);
    endfunction

    // full-turn sine in Q2.14 by quadrant folding
    function automatic longint turn_sine(int phase);
        int     ph;
        int     quad;
        int     r;
        longint mag;
        ph   = phase & 32767;
        quad = ph >> 13;
        r    = ph & 8191;
        mag  = quad[0] ? sine_ramp(8192 - r) : sine_ramp(r);
        return quad[1] ? -mag : mag;
    endfunction

    // offset the scaled point, clamp each coordinate to Q15.8, queue the vertex
    function automatic void queue_vertex(longint cx, longint cy, longint dx, longint dy,
                                         logic eop, logic lop);
        vertex_t v;
        longint  x;
        longint  y;
        x = cx + dx;
        y = cy + dy;
        if (x < COORD_MIN) x = COORD_MIN;
        if (x > COORD_MAX) x = COORD_MAX;
        if (y < COORD_MIN) y = COORD_MIN;
        if (y > COORD_MAX) y = COORD_MAX;
        v.x   = 24'(x);
        v.y   = 24'(y);
        v.eop = eop;
        v.lop = lop;
        pending_vertices.push_back(v);
        vertices_expected++;
    endfunction

    // marker outline for one accepted point under the current registers
    function automatic void predict_marker(logic signed [23:0] px, logic signed [23:0] py,
                                           logic bad);
        longint cx;
        longint cy;
        longint w;
        longint h;
        longint d;
        longint b;
        longint c;
        longint s;
        int     ph;
        if (bad || style_m < STYLE_CROSS || style_m > STYLE_TRIANGLE) begin
            points_skipped++;
            return;
        end
        // Q4.12 scale, round half up, kept at full width
        cx = (longint'(px) * longint'(scale_m) + 2048) >>> 12;
        cy = (longint'(py) * longint'(scale_m) + 2048) >>> 12;
        w  = longint'(width_m >> 1);
        case (style_m)
            STYLE_CROSS: begin
                h = w * 512;
                queue_vertex(cx, cy, -h, 0, 1'b0, 1'b0);
                queue_vertex(cx, cy, h, 0, 1'b1, 1'b0);
                queue_vertex(cx, cy, 0, -h, 1'b0, 1'b0);
                queue_vertex(cx, cy, 0, h, 1'b1, 1'b1);
            end
            STYLE_DISC: begin
                h = w * 256;
                for (int i = 0; i <= DISC_SEGMENTS; i++) begin
                    ph = (i * 32768) / DISC_SEGMENTS;
                    c  = turn_sine(ph + 8192);
                    s  = turn_sine(ph);
                    queue_vertex(cx, cy, (h * c + 8192) >>> 14, (h * s + 8192) >>> 14,
                                 i == DISC_SEGMENTS, i == DISC_SEGMENTS);
                end
            end
            STYLE_RHOMBUS: begin
                h = w * 384;
                queue_vertex(cx, cy, -h, 0, 1'b0, 1'b0);
                queue_vertex(cx, cy, 0, h, 1'b0, 1'b0);
                queue_vertex(cx, cy, h, 0, 1'b0, 1'b0);
                queue_vertex(cx, cy, 0, -h, 1'b0, 1'b0);
                queue_vertex(cx, cy, -h, 0, 1'b1, 1'b1);
            end
            STYLE_SQUARE: begin
                h = w * 256;
                queue_vertex(cx, cy, -h, -h, 1'b0, 1'b0);
                queue_vertex(cx, cy, h, -h, 1'b0, 1'b0);
                queue_vertex(cx, cy, h, h, 1'b0, 1'b0);
                queue_vertex(cx, cy, -h, h, 1'b0, 1'b0);
                queue_vertex(cx, cy, -h, -h, 1'b1, 1'b1);
            end
            default: begin
                // apex up toward -y; sqrt(3)/2 in Q0.16 is 56756
                h = w * 384;
                d = (h * 56756 + 32768) >>> 16;
                b = w * 192;
                queue_vertex(cx, cy, 0, -h, 1'b0, 1'b0);
                queue_vertex(cx, cy, d, b, 1'b0, 1'b0);
                queue_vertex(cx, cy, -d, b, 1'b0, 1'b0);
                queue_vertex(cx, cy, 0, -h, 1'b1, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel and register drivers
    // ------------------------------------------------------------------

    // one point beat; idle gaps come before valid rises, never inside a beat
    task automatic send_point(input logic signed [23:0] px, input logic signed [23:0] py,
                              input logic bad);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid      <= 1'b1;
        point_x       <= px;
        point_y       <= py;
        point_invalid <= bad;
        do @(posedge clk); while (in_stall);
        points_sent++;
        style_points[style_m] += bad ? 0 : 1;
        predict_marker(px, py, bad);
    endtask

    // hold the point channel until every outstanding vertex has come out
    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_vertices.size() != 0)
            @(posedge clk);
    endtask

    // drained, then SETTLE_CYCLES more idle clocks
    task automatic settle_block();
        drain_pause();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup, access, then idle with psel low so psel never toggles twice
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_STYLE: style_m = value[2:0];
            REG_WIDTH: width_m = value[7:0];
            REG_SCALE: scale_m = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_config(input logic [2:0] style, input logic [7:0] width,
                                input logic [15:0] scale);
        write_reg(REG_STYLE, 32'(style));
        write_reg(REG_WIDTH, 32'(width));
        write_reg(REG_SCALE, 32'(scale));
    endtask

    // ------------------------------------------------------------------
    // Random picks, biased toward the edges
    // ------------------------------------------------------------------

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return 24'(int'($urandom_range(8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_style();
        case ($urandom_range(19))
            0:       return STYLE_NONE;
            1:       return $urandom_range(1) ? STYLE_UNUSED_A : STYLE_UNUSED_B;
            default: return 3'($urandom_range(STYLE_TRIANGLE, STYLE_CROSS));
        endcase
    endfunction

    function automatic logic [7:0] rand_width();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'd4096;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // style resets to none; width 2 and unit scale show once cross is chosen
    task automatic test_reset_defaults();
        send_point(24'sh7FFFFF, 24'sh000100, 1'b0);
        settle_block();
        write_reg(REG_STYLE, 32'(STYLE_CROSS));
        send_point(24'sd256, -24'sd256, 1'b0);
        send_point(24'sd0, 24'sd0, 1'b1);
    endtask

    // every style once at a moderate odd width, plus a full-size disc
    task automatic test_marker_shapes();
        for (int st = STYLE_CROSS; st <= STYLE_TRIANGLE; st++) begin
            settle_block();
            write_config(3'(st), 8'd9, 16'd4096);
            send_point(24'sd1000, -24'sd2000, 1'b0);
        end
        settle_block();
        write_config(STYLE_DISC, 8'd255, 16'd4096);
        send_point(24'sd0, 24'sd0, 1'b0);
    endtask

    // unused codes, zero and odd widths, saturation, zero scale, skipped point
    task automatic test_special_cases();
        settle_block();
        write_config(STYLE_UNUSED_A, 8'd8, 16'd4096);
        send_point(24'sd512, 24'sd512, 1'b0);
        settle_block();
        write_reg(REG_STYLE, 32'(STYLE_UNUSED_B));
        send_point(-24'sd512, 24'sd512, 1'b0);

        settle_block();
        write_config(STYLE_SQUARE, 8'd0, 16'd8192);
        send_point(24'sd300, -24'sd300, 1'b0);
        settle_block();
        write_config(STYLE_RHOMBUS, 8'd1, 16'd4096);
        send_point(24'sd77, 24'sd99, 1'b0);
        settle_block();
        write_config(STYLE_TRIANGLE, 8'd255, 16'd2048);
        send_point(24'sh800000, 24'sh7FFFFF, 1'b0);

        // scale near 16 pushes every coordinate into the clamp
        settle_block();
        write_config(STYLE_CROSS, 8'd255, 16'hFFFF);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_point(24'sh800000, 24'sh800000, 1'b0);
        settle_block();
        write_config(STYLE_DISC, 8'd254, 16'hFFFF);
        send_point(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_point(24'sh123456, 24'sh654321, 1'b1);
        settle_block();
        write_config(STYLE_TRIANGLE, 8'd40, 16'd0);
        send_point(24'sh7FFFFF, 24'sh800000, 1'b0);
    endtask

    // four idling phases, three register settings each, random points
    task automatic test_random_traffic();
        int send_idle [0:3] = '{0, 74, 0, 30};
        int recv_idle [0:3] = '{0, 0, 74, 30};
        int made;
        int target;
        int seen_before;
        for (int p = 0; p < 4; p++) begin
            for (int seg = 0; seg < 3; seg++) begin
                settle_block();
                idle_pct  = send_idle[p];
                stall_pct = recv_idle[p];
                write_config(rand_style(), rand_width(), rand_scale());
                // only points that make vertices count, unless nothing can
                target = (style_m >= STYLE_CROSS && style_m <= STYLE_TRIANGLE) ? 24 : 6;
                made   = 0;
                while (made < target) begin
                    if (made == 12 || $urandom_range(39) == 0)
                        drain_pause();
                    seen_before = vertices_expected;
                    send_point(rand_coord(), rand_coord(), $urandom_range(9) == 0);
                    if (target < 24 || vertices_expected != seen_before)
                        made++;
                end
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Vertex checker: each taken beat against the oldest expected vertex
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_vertex
        vertex_t want;
        if (rst_n && out_valid && !out_stall) begin
            vertices_checked++;
            if (pending_vertices.size() == 0) begin
                $error("vertex beat with none expected: x %0d y %0d", vertex_x, vertex_y);
                errors++;
            end else begin
                want = pending_vertices.pop_front();
                if (vertex_x !== want.x) begin
                    $error("vertex_x expected %0d got %0d", want.x, vertex_x);
                    errors++;
                end
                if (vertex_y !== want.y) begin
                    $error("vertex_y expected %0d got %0d", want.y, vertex_y);
                    errors++;
                end
                if (end_of_polygon !== want.eop) begin
                    $error("end_of_polygon expected %0b got %0b", want.eop, end_of_polygon);
                    errors++;
                end
                if (last_of_point !== want.lop) begin
                    $error("last_of_point expected %0b got %0b", want.lop, last_of_point);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog: too long without a beat on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a beat, %0d vertices outstanding",
                     quiet_cycles, pending_vertices.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_marker_shapes();
        test_special_cases();
        test_random_traffic();

        drain_pause();
        repeat (24) @(posedge clk);
        if (pending_vertices.size() != 0) begin
            $error("%0d expected vertices never came out", pending_vertices.size());
            errors++;
        end

        $display("Covered %0d points (%0d made no vertices), %0d vertex beats checked.",
                 points_sent, points_skipped, vertices_checked);
        $display("Points per style none/cross/disc/rhombus/square/triangle/6/7: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 style_points[0], style_points[1], style_points[2], style_points[3],
                 style_points[4], style_points[5], style_points[6], style_points[7]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
